[design/pida_pkg.sv]
// Shared types and constants for the process identifier allocator.
// Used by pida_ctrl, pida_dpath and process_id_allocator; no dependencies.
package pida_pkg;

	localparam int ID_W         = 10;
	localparam int STAT_W       = 2;
	localparam int TDATA_W      = 16;
	localparam int ID_SPACE_DEF = 1024;

	localparam logic [ID_W-1:0] MIN_ID_RST = 10'd100;
	localparam logic [ID_W-1:0] MAX_ID_RST = 10'd1000;

	typedef logic [ID_W-1:0] id_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADREL = 2'd2
	} status_t;

	typedef enum logic {
		FUNC_ALLOC   = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	typedef enum logic {
		REG_MIN_ID = 1'b0,
		REG_MAX_ID = 1'b1
	} reg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic setup;
		logic next_row;
		logic wrap;
		logic alloc_hit;
		logic alloc_fail;
		logic rel_chk;
		logic push;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic empty_win;
		logic hit;
		logic last_row;
		logic can_wrap;
		logic out_free;
	} dp_stat_t;

endpackage

[design/process_id_allocator.sv]
// Top level of the process identifier allocator: stream ports, config port,
// pida_ctrl sequencer and pida_dpath bitmap datapath. Uses pida_pkg.
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+------------------------------------
//  cfg      | cfg_valid cfg_ready              | cfg_index (0 min_id, 1 max_id), cfg_data
//  s (in)   | s_tvalid s_tready                | tdata: release_id; tuser: func
//  m (out)  | m_tvalid m_tready                | tdata: given_id; tuser: status
//
// After reset a clearing pass zeroes the bitmap, one 32-bit row per cycle; no input
// beat is taken meanwhile. Release: accept, read the bitmap row, check, push to the
// output register. Allocate: setup (an empty window fails at once), then a read and a
// check per row scanned, as the single-port bitmap memory is read, then checked.
// One item is in flight; a new beat is taken while the previous result waits on m.
module process_id_allocator #(
	parameter int ID_SPACE = pida_pkg::ID_SPACE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [pida_pkg::ID_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pida_pkg::TDATA_W-1:0]   s_tdata,  // [9:0] release_id, rest zero
	input  logic                           s_tuser,  // [0] func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pida_pkg::TDATA_W-1:0]   m_tdata,  // [9:0] given_id, rest zero
	output logic [pida_pkg::STAT_W-1:0]    m_tuser   // [1:0] status
);
	import pida_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	id_t     given;
	status_t status;

	assign cfg_ready = 1'b1;

	pida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (func_t'(s_tuser)),
		.stat     (stat),
		.cmd      (cmd)
	);

	pida_dpath #(
		.ID_SPACE (ID_SPACE)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (reg_idx_t'(cfg_index)),
		.cfg_data   (cfg_data),
		.in_rel_id  (s_tdata[ID_W-1:0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_given  (given),
		.out_status (status)
	);

	assign m_tdata = {{(TDATA_W - ID_W){1'b0}}, given};
	assign m_tuser = status;

endmodule

[design/pida_ctrl.sv]
// Sequencer for the identifier allocator: clearing pass, row scan, release check.
// Depends on pida_pkg; drives pida_dpath through dp_cmd_t.
module pida_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pida_pkg::func_t    in_func,
	input  pida_pkg::dp_stat_t stat,
	output pida_pkg::dp_cmd_t  cmd
);
	import pida_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_SETUP  = 8'b0000_0100,
		S_ARD    = 8'b0000_1000,
		S_ACHK   = 8'b0001_0000,
		S_RRD    = 8'b0010_0000,
		S_RCHK   = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_func == FUNC_RELEASE) ? S_RRD : S_SETUP;
				end
			end
			S_SETUP: begin
				if (stat.empty_win) begin
					cmd.alloc_fail = 1'b1;
					state_d        = S_FINISH;
				end else begin
					cmd.setup = 1'b1;
					state_d   = S_ARD;
				end
			end
			S_ARD: state_d = S_ACHK;
			S_ACHK: begin
				if (stat.hit) begin
					cmd.alloc_hit = 1'b1;
					state_d       = S_FINISH;
				end else if (!stat.last_row) begin
					cmd.next_row = 1'b1;
					state_d      = S_ARD;
				end else if (stat.can_wrap) begin
					// restart from the window bottom, up to the start point
					cmd.wrap = 1'b1;
					state_d  = S_ARD;
				end else begin
					cmd.alloc_fail = 1'b1;
					state_d        = S_FINISH;
				end
			end
			S_RRD: state_d = S_RCHK;
			S_RCHK: begin
				cmd.rel_chk = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				// hold until the output register can take the beat
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/pida_dpath.sv]
// Datapath for the identifier allocator: usage bitmap memory, window registers,
// cursor, row scan with first-free search, result and output registers. Uses pida_pkg.
module pida_dpath #(
	parameter int ID_SPACE = pida_pkg::ID_SPACE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  pida_pkg::reg_idx_t   cfg_index,
	input  pida_pkg::id_t        cfg_data,
	input  pida_pkg::id_t        in_rel_id,
	input  pida_pkg::dp_cmd_t    cmd,
	output pida_pkg::dp_stat_t   stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pida_pkg::id_t        out_given,
	output pida_pkg::status_t    out_status
);
	import pida_pkg::*;

	localparam int IDX_W   = $clog2(ID_SPACE);
	localparam int WORD_W  = (ID_SPACE >= 64) ? 32 : ID_SPACE / 2;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int ROWS    = (ID_SPACE + WORD_W - 1) / WORD_W;
	localparam int ROW_W   = IDX_W - BIT_W;
	localparam int TOP_LIM = (ID_SPACE - 1 > 1023) ? 1023 : ID_SPACE - 1;
	localparam id_t TOP_CAP = ID_W'(TOP_LIM);

	function automatic logic [ROW_W-1:0] row_of(input id_t id);
		logic [IDX_W-1:0] ix;
		ix = IDX_W'(id);
		return ix[IDX_W-1:BIT_W];
	endfunction

	function automatic logic [BIT_W-1:0] bit_of(input id_t id);
		return id[BIT_W-1:0];
	endfunction

	logic [WORD_W-1:0] mem [ROWS];
	logic [WORD_W-1:0] rd_data_q;

	id_t              min_q, max_q, cursor_q;
	id_t              rid_q, start_q, rlo_q, rhi_q;
	logic             phase_b_q;
	logic [ROW_W-1:0] row_q;
	id_t              res_given_q, out_given_q;
	status_t          res_status_q, out_status_q;
	logic             out_valid_q;

	id_t               top_w, start_w, found_id;
	logic [BIT_W-1:0]  lo_b, hi_b, pos;
	logic [WORD_W-1:0] mask_lo, mask_hi, free_w, wdata;
	logic              hit, rel_bad, mem_we;

	assign top_w   = (max_q > TOP_CAP) ? TOP_CAP : max_q;
	assign start_w = (cursor_q < min_q || cursor_q > top_w) ? min_q : cursor_q;

	// free bits of the current row that fall inside [rlo, rhi], and the lowest of them
	always_comb begin
		lo_b    = (row_q == row_of(rlo_q)) ? bit_of(rlo_q) : '0;
		hi_b    = (row_q == row_of(rhi_q)) ? bit_of(rhi_q) : '1;
		mask_lo = {WORD_W{1'b1}} << lo_b;
		mask_hi = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_b);
		free_w  = ~rd_data_q & mask_lo & mask_hi;
		hit     = |free_w;
		pos     = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_w[i]) pos = BIT_W'(i);
		end
	end

	assign found_id = ID_W'({row_q, pos});
	assign rel_bad  = (rid_q < min_q) || (rid_q > top_w) || !rd_data_q[bit_of(rid_q)];

	always_comb begin
		mem_we = cmd.clear_wr | cmd.alloc_hit | (cmd.rel_chk & ~rel_bad);
		if (cmd.clear_wr) begin
			wdata = '0;
		end else if (cmd.alloc_hit) begin
			wdata = rd_data_q | (WORD_W'(1) << pos);
		end else begin
			wdata = rd_data_q & ~(WORD_W'(1) << bit_of(rid_q));
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[row_q];
		if (mem_we) mem[row_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= MIN_ID_RST;
			max_q       <= MAX_ID_RST;
			cursor_q    <= MIN_ID_RST;
			row_q       <= '0;
			phase_b_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_MIN_ID: min_q <= cfg_data;
					REG_MAX_ID: max_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear_wr || cmd.next_row) row_q <= row_q + ROW_W'(1);
			if (cmd.load) row_q <= row_of(in_rel_id);
			if (cmd.setup) begin
				row_q     <= row_of(start_w);
				phase_b_q <= 1'b0;
			end
			if (cmd.wrap) begin
				row_q     <= row_of(min_q);
				phase_b_q <= 1'b1;
			end
			if (cmd.alloc_hit) cursor_q <= found_id;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) rid_q <= in_rel_id;
		if (cmd.setup) begin
			start_q <= start_w;
			rlo_q   <= start_w;
			rhi_q   <= top_w;
		end
		if (cmd.wrap) begin
			rlo_q <= min_q;
			rhi_q <= start_q - ID_W'(1);
		end
		if (cmd.alloc_hit) begin
			res_given_q  <= found_id;
			res_status_q <= ST_OK;
		end
		if (cmd.alloc_fail) begin
			res_given_q  <= '0;
			res_status_q <= ST_EMPTY;
		end
		if (cmd.rel_chk) begin
			res_given_q  <= rid_q;
			res_status_q <= rel_bad ? ST_BADREL : ST_OK;
		end
		if (cmd.push) begin
			out_given_q  <= res_given_q;
			out_status_q <= res_status_q;
		end
	end

	assign stat.clear_last = (row_q == ROW_W'(ROWS - 1));
	assign stat.empty_win  = (min_q > top_w);
	assign stat.hit        = hit;
	assign stat.last_row   = (row_q == row_of(rhi_q));
	assign stat.can_wrap   = !phase_b_q && (start_q > min_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_given  = out_given_q;
	assign out_status = out_status_q;

	a_cursor_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_hit |=> cursor_q == res_given_q)
		else $error("cursor not left on the allocated identifier");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_hit |-> (found_id >= rlo_q) && (found_id <= rhi_q))
		else $error("allocated identifier outside the scan range");

	a_bad_rel_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rel_chk && ((rid_q < min_q) || (rid_q > top_w))) |-> !mem_we)
		else $error("out-of-range release modified the map");

	a_out_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.push))
		else $error("output beat raised without a push");

endmodule

[tb/process_id_allocator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for process_id_allocator: allocate and release beats
// are predicted against a local copy of the usage map. Depends on pida_pkg.
module process_id_allocator_test;
	import pida_pkg::*;

	typedef struct {
		id_t     given;
		status_t status;
	} answer_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [ID_W-1:0]     cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic [STAT_W-1:0]   m_tuser;

	// local copy of the allocator state
	bit [ID_SPACE_DEF-1:0] held_ids;
	id_t                   alloc_cursor;
	id_t                   win_lo;
	id_t                   win_hi;

	answer_t pending_answers[$];
	int      errors;
	int      hold_cycles;
	bit      pace_on;
	bit      stall_on;

	process_id_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic answer_t predict_answer(input func_t f, input id_t rid);
		answer_t a;
		int lo;
		int hi;
		int cand;
		int n;
		lo = win_lo;
		hi = win_hi;
		a.given = '0;
		a.status = ST_EMPTY;
		if (f == FUNC_ALLOC) begin
			if (lo <= hi) begin
				cand = alloc_cursor;
				if (cand < lo || cand > hi)
					cand = lo;
				for (n = 0; n < hi - lo + 1; n++) begin
					if (!held_ids[cand]) begin
						held_ids[cand] = 1'b1;
						alloc_cursor = id_t'(cand);
						a.given = id_t'(cand);
						a.status = ST_OK;
						break;
					end
					cand = (cand >= hi) ? lo : cand + 1;
				end
			end
		end else begin
			a.given = rid;
			if (int'(rid) < lo || int'(rid) > hi || !held_ids[rid]) begin
				a.status = ST_BADREL;
			end else begin
				held_ids[rid] = 1'b0;
				a.status = ST_OK;
			end
		end
		return a;
	endfunction

	// pick a held id inside the window; any id if the window is empty, or any id inside it if none is held
	function automatic id_t pick_held();
		int lo;
		int hi;
		int span;
		int start;
		int k;
		int c;
		lo = win_lo;
		hi = win_hi;
		if (lo > hi)
			return id_t'($urandom_range(ID_SPACE_DEF - 1));
		span = hi - lo + 1;
		start = $urandom_range(span - 1);
		for (k = 0; k < span; k++) begin
			c = lo + (start + k) % span;
			if (held_ids[c])
				return id_t'(c);
		end
		return id_t'($urandom_range(hi, lo));
	endfunction

	// caller sits on a rising edge; valid is left high after the beat is taken
	task automatic send_request(input func_t f, input id_t rid);
		bit taken;
		while (pace_on && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_W-ID_W){1'b0}}, rid};
		s_tuser  <= f;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		pending_answers.push_back(predict_answer(f, rid));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input id_t value);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		if (idx == REG_MIN_ID)
			win_lo = value;
		else
			win_hi = value;
		@(posedge clk);
	endtask

	task automatic set_window(input id_t lo, input id_t hi);
		wait_drained();
		write_reg(REG_MIN_ID, lo);
		write_reg(REG_MAX_ID, hi);
	endtask

	task automatic check_answer(input logic [TDATA_W-1:0] data,
		input logic [STAT_W-1:0] stat);
		answer_t exp;
		if (pending_answers.size() == 0) begin
			$error("unexpected result beat: given_id %0d status %0d", data[ID_W-1:0], stat);
			errors++;
		end else begin
			exp = pending_answers.pop_front();
			if (data[ID_W-1:0] !== exp.given) begin
				$error("given_id: expected %0d, got %0d", exp.given, data[ID_W-1:0]);
				errors++;
			end
			if (stat !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, stat);
				errors++;
			end
		end
	endtask

	// result side: random stalls plus an optional long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= !(stall_on && $urandom_range(99) < 11);
			end
			@(negedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				check_answer(m_tdata, m_tuser);
		end
	end

	task automatic test_reset_window();
		send_request(FUNC_ALLOC, '1);
		send_request(FUNC_ALLOC, '0);
		send_request(FUNC_RELEASE, 10'd100);
		send_request(FUNC_RELEASE, 10'd100);
		send_request(FUNC_RELEASE, 10'd0);
		send_request(FUNC_RELEASE, 10'd1023);
		// cursor still on the last allocated id, which is held: the search moves on past it
		send_request(FUNC_ALLOC, 10'h2AA);
	endtask

	task automatic test_exhaust_and_wrap();
		int i;
		// cursor lies outside the new window, search starts at its bottom
		set_window(10'd5, 10'd8);
		for (i = 0; i < 5; i++)
			send_request(FUNC_ALLOC, 10'h155);
		send_request(FUNC_RELEASE, 10'd6);
		send_request(FUNC_ALLOC, '0);
		// held from the earlier window but now out of range
		send_request(FUNC_RELEASE, 10'd101);
	endtask

	task automatic test_window_extremes();
		set_window(10'd600, 10'd599);
		send_request(FUNC_ALLOC, '0);
		send_request(FUNC_RELEASE, 10'd600);
		wait_drained();
		write_reg(REG_MAX_ID, 10'd1023);
		write_reg(REG_MIN_ID, 10'd1023);
		send_request(FUNC_ALLOC, '0);
		send_request(FUNC_ALLOC, '0);
		set_window(10'd0, 10'd0);
		send_request(FUNC_ALLOC, '1);
		send_request(FUNC_RELEASE, 10'd0);
		set_window(10'd0, 10'd1023);
		send_request(FUNC_ALLOC, '0);
		send_request(FUNC_ALLOC, '0);
		send_request(FUNC_RELEASE, 10'd1023);
		send_request(FUNC_RELEASE, 10'd1023);
	endtask

	task automatic test_backpressure();
		int i;
		set_window(10'd200, 10'd263);
		pace_on = 1'b0;
		hold_cycles = 200;
		for (i = 0; i < 12; i++)
			send_request(i % 3 == 2 ? FUNC_RELEASE : FUNC_ALLOC, pick_held());
		pace_on = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int phase;
		int i;
		int kind;
		int lo;
		int hi;
		int r;
		for (phase = 0; phase < 10; phase++) begin
			kind = $urandom_range(9);
			if (kind == 0) begin
				lo = $urandom_range(1023, 1);
				hi = $urandom_range(lo - 1);
			end else if (kind == 1) begin
				lo = $urandom_range(50);
				hi = $urandom_range(1023, 980);
			end else begin
				lo = $urandom_range(1023);
				hi = lo + $urandom_range(39);
				if (hi > 1023)
					hi = 1023;
			end
			set_window(id_t'(lo), id_t'(hi));
			pace_on = (phase != 3);
			stall_on = (phase != 3);
			for (i = 0; i < 160; i++) begin
				r = $urandom_range(99);
				if (r < 55)
					send_request(FUNC_ALLOC, id_t'($urandom));
				else if (r < 87)
					send_request(FUNC_RELEASE, pick_held());
				else
					send_request(FUNC_RELEASE, id_t'($urandom));
			end
		end
		pace_on = 1'b1;
		stall_on = 1'b1;
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		errors    = 0;
		hold_cycles = 0;
		pace_on   = 1'b1;
		stall_on  = 1'b1;
		held_ids  = '0;
		win_lo    = MIN_ID_RST;
		win_hi    = MAX_ID_RST;
		alloc_cursor = MIN_ID_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_exhaust_and_wrap();
		test_window_extremes();
		test_backpressure();
		test_random_traffic();

		wait_drained();
		// allow stray beats to show up
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_answers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
design/pida_pkg.sv
design/pida_ctrl.sv
design/pida_dpath.sv
design/process_id_allocator.sv
tb/process_id_allocator_test.sv
